@@ hdl/nlv_pkg.sv @@
package nlv_pkg;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_CONTENT,
    PH_TRAIL,
    PH_ENDED
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic       seen_point;
    logic       seen_sign;
    logic       seen_digit;
    logic       seen_exponent;
    logic       rejected;
    logic [2:0] content_count;
    logic       nan_match;
    logic       inf_match;
    logic       neginf_match;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    phase:         PH_LEAD,
    seen_point:    1'b0,
    seen_sign:     1'b0,
    seen_digit:    1'b0,
    seen_exponent: 1'b0,
    rejected:      1'b0,
    content_count: 3'd0,
    nan_match:     1'b1,
    inf_match:     1'b1,
    neginf_match:  1'b1
  };

  localparam logic [1:0] VERDICT_INVALID = 2'd0;
  localparam logic [1:0] VERDICT_NUMBER  = 2'd1;
  localparam logic [1:0] VERDICT_SPECIAL = 2'd2;

  localparam logic [2:0] COUNT_MAX = 3'd5;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_POINT   = 8'h2e;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_LOWER_E = 8'h65;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_UPPER_I = 8'h49;
  localparam logic [7:0] CH_UPPER_N = 8'h4e;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_GAP   = 8'h20;

  function automatic logic nan_at(input logic [2:0] pos, input logic [7:0] up);
    logic hit;
    unique case (pos)
      3'd0:    hit = (up == CH_UPPER_N);
      3'd1:    hit = (up == CH_UPPER_A);
      3'd2:    hit = (up == CH_UPPER_N);
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic inf_at(input logic [2:0] pos, input logic [7:0] up);
    logic hit;
    unique case (pos)
      3'd0:    hit = (up == CH_UPPER_I);
      3'd1:    hit = (up == CH_UPPER_N);
      3'd2:    hit = (up == CH_UPPER_F);
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic neginf_at(input logic [2:0] pos, input logic [7:0] up);
    logic hit;
    unique case (pos)
      3'd0:    hit = (up == CH_MINUS);
      3'd1:    hit = (up == CH_UPPER_I);
      3'd2:    hit = (up == CH_UPPER_N);
      3'd3:    hit = (up == CH_UPPER_F);
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

@@ hdl/nlv_step.sv @@
module nlv_step (
  input  nlv_pkg::scan_state_t cur,
  input  logic [7:0]           char_byte,
  input  logic                 has_char,
  input  logic                 decimal_mode,
  output nlv_pkg::scan_state_t nxt,
  output logic [1:0]           verdict
);

  logic       is_space;
  logic       is_nul;
  logic       content;
  logic [7:0] up;

  assign is_space = (char_byte == nlv_pkg::CH_SPACE) || (char_byte == nlv_pkg::CH_TAB) ||
                    (char_byte == nlv_pkg::CH_LF) || (char_byte == nlv_pkg::CH_CR);
  assign is_nul   = (char_byte == nlv_pkg::CH_NUL);
  assign up = ((char_byte >= nlv_pkg::CH_LOWER_A) && (char_byte <= nlv_pkg::CH_LOWER_Z)) ?
              (char_byte - nlv_pkg::CASE_GAP) : char_byte;

  always_comb begin
    nxt     = cur;
    content = 1'b0;
    if (has_char) begin
      unique case (cur.phase)
        nlv_pkg::PH_LEAD: begin
          if (is_nul) begin
            nxt.phase = nlv_pkg::PH_ENDED;
          end else if (!is_space) begin
            nxt.phase = nlv_pkg::PH_CONTENT;
            content   = 1'b1;
          end
        end
        nlv_pkg::PH_CONTENT: begin
          if (is_space) begin
            nxt.phase = nlv_pkg::PH_TRAIL;
          end else if (is_nul) begin
            nxt.phase = nlv_pkg::PH_ENDED;
          end else begin
            content = 1'b1;
          end
        end
        nlv_pkg::PH_TRAIL: begin
          if (!is_space) begin
            nxt.rejected     = 1'b1;
            nxt.nan_match    = 1'b0;
            nxt.inf_match    = 1'b0;
            nxt.neginf_match = 1'b0;
            nxt.phase        = is_nul ? nlv_pkg::PH_ENDED : nlv_pkg::PH_CONTENT;
          end
        end
        nlv_pkg::PH_ENDED: begin
        end
        default: begin
        end
      endcase
    end

    if (content) begin
      nxt.nan_match    = cur.nan_match && nlv_pkg::nan_at(cur.content_count, up);
      nxt.inf_match    = cur.inf_match && nlv_pkg::inf_at(cur.content_count, up);
      nxt.neginf_match = cur.neginf_match && nlv_pkg::neginf_at(cur.content_count, up);
      if (cur.content_count < nlv_pkg::COUNT_MAX) begin
        nxt.content_count = cur.content_count + 3'd1;
      end
      if (!cur.rejected) begin
        priority if ((char_byte == nlv_pkg::CH_PLUS) || (char_byte == nlv_pkg::CH_MINUS)) begin
          if (cur.seen_sign || cur.seen_digit) begin
            nxt.rejected = 1'b1;
          end else begin
            nxt.seen_sign = 1'b1;
          end
        end else if ((char_byte == nlv_pkg::CH_UPPER_E) ||
                     (char_byte == nlv_pkg::CH_LOWER_E)) begin
          if (!cur.seen_digit || cur.seen_exponent || decimal_mode) begin
            nxt.rejected = 1'b1;
          end else begin
            nxt.seen_point    = 1'b0;
            nxt.seen_sign     = 1'b0;
            nxt.seen_digit    = 1'b0;
            nxt.seen_exponent = 1'b1;
          end
        end else if (char_byte == nlv_pkg::CH_POINT) begin
          if (cur.seen_point || cur.seen_exponent) begin
            nxt.rejected = 1'b1;
          end else begin
            nxt.seen_point = 1'b1;
          end
        end else if ((char_byte >= nlv_pkg::CH_ZERO) && (char_byte <= nlv_pkg::CH_NINE)) begin
          nxt.seen_digit = 1'b1;
        end else begin
          nxt.rejected = 1'b1;
        end
      end
    end
  end

  always_comb begin
    priority if (nxt.content_count == 3'd0) begin
      verdict = nlv_pkg::VERDICT_INVALID;
    end else if (nxt.seen_digit && !nxt.rejected) begin
      verdict = nlv_pkg::VERDICT_NUMBER;
    end else if (decimal_mode) begin
      verdict = nlv_pkg::VERDICT_INVALID;
    end else if (((nxt.nan_match || nxt.inf_match) && (nxt.content_count == 3'd3)) ||
                 (nxt.neginf_match && (nxt.content_count == 3'd4))) begin
      verdict = nlv_pkg::VERDICT_SPECIAL;
    end else begin
      verdict = nlv_pkg::VERDICT_INVALID;
    end
  end

endmodule

@@ hdl/numeric_lexical_validator.sv @@
// Channel  Handshake            Payload
// in       in_valid/in_stall    in_char_byte, in_has_char, in_last
// out      out_valid/out_stall  out_verdict
// cfg      cfg_valid/cfg_ready  cfg_decimal_mode
//
// One byte is accepted every cycle unless in_stall is high; the verdict follows its last byte.
// The input register feeds one pass of flag logic into the scan state and the result register.
// Reset is synchronous and clears the scan state, the valid flags and the mode register.
// A held result freezes the scan state and the result register; the input register still
// fills when empty, and the input stalls only while that register is full behind it.
module numeric_lexical_validator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_byte,
  input  logic       in_has_char,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_verdict,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_decimal_mode
);

  logic                 advance;
  logic                 s1_load;
  logic                 s1_valid_r;
  logic [7:0]           s1_byte_r;
  logic                 s1_has_r;
  logic                 s1_last_r;
  logic                 decimal_mode_r;
  nlv_pkg::scan_state_t state_r;
  nlv_pkg::scan_state_t state_nxt;
  logic [1:0]           verdict_nxt;
  logic                 out_valid_r;
  logic [1:0]           out_verdict_r;

  assign advance   = !(out_valid_r && out_stall);
  assign s1_load   = advance || !s1_valid_r;
  assign in_stall  = !s1_load;
  assign cfg_ready = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

  nlv_step u_step (
    .cur          (state_r),
    .char_byte    (s1_byte_r),
    .has_char     (s1_has_r),
    .decimal_mode (decimal_mode_r),
    .nxt          (state_nxt),
    .verdict      (verdict_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decimal_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      decimal_mode_r <= cfg_decimal_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_byte_r <= in_char_byte;
      s1_has_r  <= in_has_char;
      s1_last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nlv_pkg::SCAN_RESET;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && s1_last_r;
      if (s1_valid_r) begin
        state_r <= s1_last_r ? nlv_pkg::SCAN_RESET : state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r && s1_last_r) begin
      out_verdict_r <= verdict_nxt;
    end
  end

endmodule

@@ tb/verdict_checker.sv @@
module verdict_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_char_byte,
  input  logic       in_has_char,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_verdict,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_decimal_mode,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] WORD_NAN    = "NAN";
  localparam logic [31:0] WORD_INF    = "INF";
  localparam logic [31:0] WORD_NEGINF = "-INF";
  localparam int          MAX_PRINTS  = 100;

  logic                 decimal_mode;
  nlv_pkg::scan_state_t scan;
  logic [1:0]           expected_verdicts[$];
  logic [1:0]           want;
  int                   errors;

  function automatic logic is_blank(input logic [7:0] b);
    return b == nlv_pkg::CH_SPACE || b == nlv_pkg::CH_TAB || b == nlv_pkg::CH_LF ||
           b == nlv_pkg::CH_CR;
  endfunction

  function automatic logic word_hit(input logic [31:0] word, input int len,
                                    input logic [2:0] pos, input logic [7:0] up);
    int idx;
    if (int'(pos) >= len) return 1'b0;
    idx = 8 * (len - 1 - int'(pos));
    return word[idx +: 8] == up;
  endfunction

  function automatic nlv_pkg::scan_state_t scan_content(input nlv_pkg::scan_state_t s,
                                                        input logic [7:0] b,
                                                        input logic dec);
    nlv_pkg::scan_state_t n;
    logic [7:0]           up;
    n  = s;
    up = (b >= nlv_pkg::CH_LOWER_A && b <= nlv_pkg::CH_LOWER_Z) ? b - nlv_pkg::CASE_GAP : b;
    n.nan_match    = s.nan_match && word_hit(WORD_NAN, 3, s.content_count, up);
    n.inf_match    = s.inf_match && word_hit(WORD_INF, 3, s.content_count, up);
    n.neginf_match = s.neginf_match && word_hit(WORD_NEGINF, 4, s.content_count, up);
    if (s.content_count < nlv_pkg::COUNT_MAX) n.content_count = s.content_count + 3'd1;
    if (s.rejected) return n;
    if (b == nlv_pkg::CH_PLUS || b == nlv_pkg::CH_MINUS) begin
      if (s.seen_sign || s.seen_digit) n.rejected = 1'b1;
      else n.seen_sign = 1'b1;
    end else if (b == nlv_pkg::CH_UPPER_E || b == nlv_pkg::CH_LOWER_E) begin
      if (!s.seen_digit || s.seen_exponent || dec) begin
        n.rejected = 1'b1;
      end else begin
        n.seen_point    = 1'b0;
        n.seen_sign     = 1'b0;
        n.seen_digit    = 1'b0;
        n.seen_exponent = 1'b1;
      end
    end else if (b == nlv_pkg::CH_POINT) begin
      if (s.seen_point || s.seen_exponent) n.rejected = 1'b1;
      else n.seen_point = 1'b1;
    end else if (b >= nlv_pkg::CH_ZERO && b <= nlv_pkg::CH_NINE) begin
      n.seen_digit = 1'b1;
    end else begin
      n.rejected = 1'b1;
    end
    return n;
  endfunction

  function automatic nlv_pkg::scan_state_t scan_byte(input nlv_pkg::scan_state_t s,
                                                     input logic [7:0] b,
                                                     input logic dec);
    nlv_pkg::scan_state_t n;
    n = s;
    case (s.phase)
      nlv_pkg::PH_LEAD: begin
        if (b == nlv_pkg::CH_NUL) begin
          n.phase = nlv_pkg::PH_ENDED;
        end else if (!is_blank(b)) begin
          n.phase = nlv_pkg::PH_CONTENT;
          n = scan_content(n, b, dec);
        end
      end
      nlv_pkg::PH_CONTENT: begin
        if (is_blank(b)) n.phase = nlv_pkg::PH_TRAIL;
        else if (b == nlv_pkg::CH_NUL) n.phase = nlv_pkg::PH_ENDED;
        else n = scan_content(n, b, dec);
      end
      nlv_pkg::PH_TRAIL: begin
        if (!is_blank(b)) begin
          n.rejected     = 1'b1;
          n.nan_match    = 1'b0;
          n.inf_match    = 1'b0;
          n.neginf_match = 1'b0;
          n.phase        = (b == nlv_pkg::CH_NUL) ? nlv_pkg::PH_ENDED : nlv_pkg::PH_CONTENT;
        end
      end
      default: ;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] predict_verdict(input nlv_pkg::scan_state_t s,
                                                 input logic dec);
    if (s.content_count == 3'd0) return nlv_pkg::VERDICT_INVALID;
    if (s.seen_digit && !s.rejected) return nlv_pkg::VERDICT_NUMBER;
    if (dec) return nlv_pkg::VERDICT_INVALID;
    if ((s.nan_match && s.content_count == 3'd3) || (s.inf_match && s.content_count == 3'd3) ||
        (s.neginf_match && s.content_count == 3'd4))
      return nlv_pkg::VERDICT_SPECIAL;
    return nlv_pkg::VERDICT_INVALID;
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTS) $display("[%0t] ERROR: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      decimal_mode = 1'b0;
      scan         = nlv_pkg::SCAN_RESET;
      expected_verdicts.delete();
      errors       = 0;
    end else begin
      if (cfg_valid && cfg_ready) decimal_mode = cfg_decimal_mode;
      if (in_valid && !in_stall) begin
        if (in_has_char) scan = scan_byte(scan, in_char_byte, decimal_mode);
        if (in_last) begin
          expected_verdicts.push_back(predict_verdict(scan, decimal_mode));
          scan = nlv_pkg::SCAN_RESET;
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("verdict %0d arrived with none outstanding", out_verdict));
        end else begin
          want = expected_verdicts.pop_front();
          if (out_verdict !== want)
            report_mismatch($sformatf("verdict %0d, expected %0d", out_verdict, want));
        end
      end
    end
    fail_count <= errors;
    pending    <= expected_verdicts.size();
  end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS   = 250;
  localparam int PHASES        = 6;

  typedef struct packed {
    logic       has;
    logic [7:0] b;
  } char_item_t;

  logic       clk;
  logic       rst_n            = 1'b0;
  logic       in_valid         = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_byte     = 8'h00;
  logic       in_has_char      = 1'b0;
  logic       in_last          = 1'b0;
  logic       out_valid;
  logic       out_stall        = 1'b0;
  logic [1:0] out_verdict;
  logic       cfg_valid        = 1'b0;
  logic       cfg_ready;
  logic       cfg_decimal_mode = 1'b0;
  int         fail_count;
  int         pending;

  char_item_t text_q[$];
  int         items_sent  = 0;
  int         burst_left  = 0;
  bit         steady      = 1'b0;
  bit         sprinkle    = 1'b0;
  int         cycle_count = 0;
  int         stall_left  = 0;
  int         stall_style = 0;

  numeric_lexical_validator u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_byte     (in_char_byte),
    .in_has_char      (in_has_char),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_verdict      (out_verdict),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_decimal_mode (cfg_decimal_mode)
  );

  verdict_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_byte     (in_char_byte),
    .in_has_char      (in_has_char),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_verdict      (out_verdict),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_decimal_mode (cfg_decimal_mode),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The receiver changes its stall style each time a random countdown runs out.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left  <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 1) == 0);
      2:       out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= stall_left[2];
    endcase
  end

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0:       return nlv_pkg::CH_SPACE;
      1:       return nlv_pkg::CH_TAB;
      2:       return nlv_pkg::CH_LF;
      default: return nlv_pkg::CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] pick_mixed();
    string letters;
    letters = "NAIFnaifxZ";
    case ($urandom_range(0, 7))
      0:       return nlv_pkg::CH_ZERO + 8'($urandom_range(0, 9));
      1:       return $urandom_range(0, 1) ? nlv_pkg::CH_PLUS : nlv_pkg::CH_MINUS;
      2:       return $urandom_range(0, 1) ? nlv_pkg::CH_UPPER_E : nlv_pkg::CH_LOWER_E;
      3:       return nlv_pkg::CH_POINT;
      4:       return blank_char();
      5:       return nlv_pkg::CH_NUL;
      6:       return letters[$urandom_range(0, 9)];
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_void();
    text_q.push_back('{has: 1'b0, b: 8'($urandom_range(0, 255))});
  endtask

  task automatic add_byte(input logic [7:0] b);
    if (sprinkle && $urandom_range(0, 11) == 0) add_void();
    text_q.push_back('{has: 1'b1, b: b});
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_blanks(input int max_n);
    repeat ($urandom_range(0, max_n)) add_byte(blank_char());
  endtask

  task automatic add_digits(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) add_byte(nlv_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic add_word();
    string w;
    int    n;
    logic [7:0] c;
    case ($urandom_range(0, 2))
      0:       w = "NAN";
      1:       w = "INF";
      default: w = "-INF";
    endcase
    n = w.len();
    if ($urandom_range(0, 3) == 0) n = $urandom_range(0, w.len() - 1);
    for (int i = 0; i < n; i++) begin
      c = w[i];
      if (c != nlv_pkg::CH_MINUS && $urandom_range(0, 1)) c = c | nlv_pkg::CASE_GAP;
      add_byte(c);
    end
    if ($urandom_range(0, 5) == 0) add_byte(pick_mixed());
  endtask

  task automatic add_number();
    add_blanks(2);
    if ($urandom_range(0, 2) == 0)
      add_byte($urandom_range(0, 1) ? nlv_pkg::CH_PLUS : nlv_pkg::CH_MINUS);
    add_digits(0, 3);
    if ($urandom_range(0, 1)) begin
      add_byte(nlv_pkg::CH_POINT);
      add_digits(0, 3);
    end
    if ($urandom_range(0, 2) == 0) begin
      add_byte($urandom_range(0, 1) ? nlv_pkg::CH_UPPER_E : nlv_pkg::CH_LOWER_E);
      if ($urandom_range(0, 1))
        add_byte($urandom_range(0, 1) ? nlv_pkg::CH_PLUS : nlv_pkg::CH_MINUS);
      add_digits(0, 2);
    end
    add_blanks(2);
    if ($urandom_range(0, 5) == 0) begin
      add_byte(nlv_pkg::CH_NUL);
      repeat ($urandom_range(0, 2)) add_byte(pick_mixed());
    end
  endtask

  task automatic build_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: add_number();
      5, 6: begin
        add_blanks(1);
        add_word();
        add_blanks(1);
      end
      7: begin
        add_digits(1, 2);
        add_byte(pick_mixed());
        add_digits(0, 2);
      end
      default: repeat ($urandom_range(0, 6)) add_byte(pick_mixed());
    endcase
    if (sprinkle && $urandom_range(0, 7) == 0) add_void();
  endtask

  task automatic send_item(input char_item_t it, input logic fin);
    in_valid     <= 1'b1;
    in_char_byte <= it.b;
    in_has_char  <= it.has;
    in_last      <= fin;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic send_value();
    if (text_q.size() == 0) add_void();
    for (int i = 0; i < text_q.size(); i++) send_item(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    cfg_valid        <= 1'b1;
    cfg_decimal_mode <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    settle_idle();
    write_mode(1'b0);
    send_value();
    add_text("1");
    send_value();
    add_text("-iNf");
    add_void();
    send_value();
    add_text("-");
    send_value();
    add_text("nan");
    send_value();
    add_text("1 2");
    send_value();
    add_byte(nlv_pkg::CH_NUL);
    add_text("x");
    send_value();
    add_text("5E+1");
    send_value();
    add_byte(nlv_pkg::CH_TAB);
    add_text(".7");
    add_byte(nlv_pkg::CH_NUL);
    add_byte(8'hff);
    send_value();

    settle_idle();
    write_mode(1'b1);
    add_text("1e5");
    send_value();
    add_text("INF");
    send_value();
    add_text("-.5");
    send_value();

    sprinkle = 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      settle_idle();
      write_mode(ph == 0 ? 1'b0 : ph == 1 ? 1'b1 : logic'($urandom_range(0, 1)));
      steady = ($urandom_range(0, 3) == 0);
      burst_left = 0;
      for (int target = items_sent + PHASE_ITEMS; items_sent < target; ) begin
        build_value();
        send_value();
      end
    end

    settle_idle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/nlv_pkg.sv
hdl/nlv_step.sv
hdl/numeric_lexical_validator.sv
tb/verdict_checker.sv
tb/tb_top.sv
